// File: rtl/core/sfh_pkg.sv
// shared constants and arithmetic helpers for the stereo fir high-pass filter
package sfh_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int PROD_W       = 2 * SAMPLE_W;
    localparam int ACC_W        = 40;
    localparam int FRAC_BITS    = 15;
    localparam int TAPS_DEFAULT = 23;
    localparam int TAPS_MAX     = 64;
    localparam int COEF_IDX_W   = $clog2(TAPS_MAX);
    localparam int COEF_COUNT   = 23;

    // q1.15 high-pass coefficients, entry 0 applies to the newest sample
    localparam logic signed [SAMPLE_W-1:0] COEF_TABLE [COEF_COUNT] = '{
        16'sd193,    16'sd2518,   16'sd204,    16'sd107,    -16'sd370,   -16'sd994,
        -16'sd1729,  -16'sd2500,  -16'sd3220,  -16'sd3811,  -16'sd4196,  16'sd28436,
        -16'sd4196,  -16'sd3811,  -16'sd3220,  -16'sd2500,  -16'sd1729,  -16'sd994,
        -16'sd370,   16'sd107,    16'sd204,    16'sd2518,   16'sd193
    };

    // taps past the end of the table weigh zero
    function automatic logic signed [SAMPLE_W-1:0] coef_q15(input logic [COEF_IDX_W-1:0] k);
        logic signed [SAMPLE_W-1:0] c;
        c = '0;
        if (k < COEF_IDX_W'(COEF_COUNT))
        begin
            c = COEF_TABLE[k[4:0]];
        end
        return c;
    endfunction

    // divide by 2^15 toward zero, then clamp to the sample range
    function automatic logic signed [SAMPLE_W-1:0] finish(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0]           biased;
        logic signed [ACC_W-FRAC_BITS-1:0] q;
        logic signed [SAMPLE_W-1:0]        r;
        biased = acc + (acc[ACC_W-1] ? ACC_W'(32767) : ACC_W'(0));
        q      = biased[ACC_W-1:FRAC_BITS];
        if (q > (ACC_W-FRAC_BITS)'(32767))
        begin
            r = 16'sh7FFF;
        end
        else if (q < -(ACC_W-FRAC_BITS)'(32768))
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = q[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/sfh_ram.sv
// generic single-write, single-read ram with registered read data
module sfh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 23,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/stereo_fir_highpass.sv
// stereo fir high-pass filter with one shared multiply-accumulate unit
//
// channel   | dir | handshake                    | word contents
// ----------+-----+------------------------------+---------------------------------
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | [15:0] left_sample, [31:16] right_sample
// m_axis    | out | m_axis_tvalid/m_axis_tready  | [15:0] left_out,    [31:16] right_out
// cfg       | in  | cfg_valid/cfg_ready          | [0] filter_enable
//
// filtered word: the single 16x16 multiplier does one left and one right product per
//   tap, the sequencer stepping through S_RD, S_ML/S_MR per tap, S_FLUSH, S_FIN, S_DONE
// bypass word: goes straight to S_DONE through the result registers, delay lines untouched
// reset clears the delay lines at once through per-entry valid bits, no sweep
// input is taken only while the sequencer idles; a held result waits in the output
//   register, so the next word is accepted while the sink stalls
module stereo_fir_highpass import sfh_pkg::*; #(
    parameter int TAPS = TAPS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] left_sample, [31:16] right_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] left_out, [31:16] right_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data        // [0] filter_enable
);

    localparam int AW = $clog2(TAPS);
    localparam logic [AW-1:0] LAST_IDX = AW'(TAPS - 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD    = 7'b0000010,   // first delay-line read in flight
        S_ML    = 7'b0000100,   // left product, next read issued
        S_MR    = 7'b0001000,   // right product
        S_FLUSH = 7'b0010000,   // last product folds into the accumulator
        S_FIN   = 7'b0100000,   // scale and saturate
        S_DONE  = 7'b1000000    // wait for the output register
    } state_t;

    state_t state_reg, state_next;

    logic                       enable_reg;
    logic [AW-1:0]              pos_reg, pos_next;
    logic [AW-1:0]              idx_reg, idx_next, idx_dec;
    logic [AW-1:0]              k_reg, k_next;
    logic                       last_reg, last_next;
    logic [TAPS-1:0]            valid_reg, valid_next;
    logic signed [SAMPLE_W-1:0] coef_reg, coef_next;
    logic signed [SAMPLE_W-1:0] hold_r_reg, hold_r_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic                       prod_valid_reg, prod_valid_next;
    logic                       prod_right_reg, prod_right_next;
    logic signed [ACC_W-1:0]    acc_l_reg, acc_l_next;
    logic signed [ACC_W-1:0]    acc_r_reg, acc_r_next;
    logic signed [SAMPLE_W-1:0] res_l_reg, res_l_next;
    logic signed [SAMPLE_W-1:0] res_r_reg, res_r_next;
    logic                       out_valid_reg, out_valid_next;
    logic [31:0]                out_data_reg, out_data_next;

    logic                       in_accept;
    logic                       out_load;
    logic                       ram_wr_en;
    logic                       ram_rd_en;
    logic [AW-1:0]              ram_rd_addr;
    logic [31:0]                ram_rd_data;
    logic [31:0]                tap_word;
    logic signed [SAMPLE_W-1:0] mul_b;
    logic signed [PROD_W-1:0]   mul_out;
    logic signed [ACC_W-1:0]    prod_ext;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // both channels share one ram word: right in the high half
    assign ram_wr_en   = in_accept && enable_reg;
    assign idx_dec     = (idx_reg == '0) ? LAST_IDX : idx_reg - AW'(1);
    assign ram_rd_en   = (state_reg == S_RD) || ((state_reg == S_ML) && !last_next);
    assign ram_rd_addr = (state_reg == S_RD) ? idx_reg : idx_dec;

    sfh_ram #(
        .WIDTH (32),
        .DEPTH (TAPS)
    ) u_delay_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (pos_reg),
        .wr_data (s_axis_tdata),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // entries never written since reset read as zero
    assign tap_word = valid_reg[idx_reg] ? ram_rd_data : 32'd0;

    // the shared multiplier: left half in S_ML, held right half in S_MR
    assign mul_b    = (state_reg == S_ML) ? signed'(tap_word[15:0]) : hold_r_reg;
    assign mul_out  = coef_reg * mul_b;
    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        k_next          = k_reg;
        last_next       = last_reg;
        valid_next      = valid_reg;
        coef_next       = coef_reg;
        hold_r_next     = hold_r_reg;
        prod_next       = prod_reg;
        prod_valid_next = 1'b0;
        prod_right_next = 1'b0;
        acc_l_next      = acc_l_reg;
        acc_r_next      = acc_r_reg;
        res_l_next      = res_l_reg;
        res_r_next      = res_r_reg;

        // accumulate the product from the previous cycle
        if (prod_valid_reg)
        begin
            if (prod_right_reg)
            begin
                acc_r_next = acc_r_reg + prod_ext;
            end
            else
            begin
                acc_l_next = acc_l_reg + prod_ext;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (enable_reg)
                    begin
                        valid_next[pos_reg] = 1'b1;
                        pos_next   = (pos_reg == LAST_IDX) ? '0 : pos_reg + AW'(1);
                        idx_next   = pos_reg;
                        k_next     = '0;
                        coef_next  = coef_q15(COEF_IDX_W'(0));
                        acc_l_next = '0;
                        acc_r_next = '0;
                        state_next = S_RD;
                    end
                    else
                    begin
                        res_l_next = signed'(s_axis_tdata[15:0]);
                        res_r_next = signed'(s_axis_tdata[31:16]);
                        state_next = S_DONE;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_ML;
            end
            S_ML:
            begin
                last_next       = (k_reg == LAST_IDX);
                prod_next       = mul_out;
                prod_valid_next = 1'b1;
                hold_r_next     = signed'(tap_word[31:16]);
                k_next          = k_reg + AW'(1);
                idx_next        = idx_dec;
                state_next      = S_MR;
            end
            S_MR:
            begin
                prod_next       = mul_out;
                prod_valid_next = 1'b1;
                prod_right_next = 1'b1;
                coef_next       = coef_q15(COEF_IDX_W'(k_reg));
                state_next      = last_reg ? S_FLUSH : S_ML;
            end
            S_FLUSH:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                res_l_next = finish(acc_l_reg);
                res_r_next = finish(acc_r_reg);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register parts the sink from the sequencer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {res_r_reg, res_l_reg};
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            enable_reg     <= 1'b0;
            pos_reg        <= '0;
            k_reg          <= '0;
            last_reg       <= 1'b0;
            valid_reg      <= '0;
            prod_valid_reg <= 1'b0;
            prod_right_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            k_reg          <= k_next;
            last_reg       <= last_next;
            valid_reg      <= valid_next;
            prod_valid_reg <= prod_valid_next;
            prod_right_reg <= prod_right_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                enable_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        coef_reg     <= coef_next;
        hold_r_reg   <= hold_r_next;
        prod_reg     <= prod_next;
        acc_l_reg    <= acc_l_next;
        acc_r_reg    <= acc_r_next;
        res_l_reg    <= res_l_next;
        res_r_reg    <= res_r_next;
        out_data_reg <= out_data_next;
    end

    // a delay-line entry once written stays valid until reset
    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (($past(valid_reg) & ~valid_reg) == '0))
        else $error("delay line valid bit cleared");

    // products only come out of the two multiply steps
    a_prod_source: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid_reg |-> ($past(state_reg) == S_ML || $past(state_reg) == S_MR))
        else $error("product without a multiply step");

    // every product has been folded in before scaling
    a_fin_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> !prod_valid_reg)
        else $error("scaling with a product still pending");

    // tap counter stays within the delay line
    a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ML) |-> (k_reg <= LAST_IDX))
        else $error("tap counter out of range");

endmodule

// File: sim/tb_top.sv
// self-checking testbench for the stereo fir high-pass filter
`timescale 1ns / 100ps

module tb_top;

    import sfh_pkg::SAMPLE_W;

    localparam int NTAPS      = 23;
    localparam int LATENCY    = 2 * NTAPS + 4;   // filtered word, accept to output
    localparam int HALF_ITEMS = 115;             // random words per enable setting

    // q1.15 high-pass taps, entry 0 weighs the newest sample
    localparam int TAP_COEF [NTAPS] = '{
        193, 2518, 204, 107, -370, -994, -1729, -2500, -3220, -3811, -4196,
        28436,
        -4196, -3811, -3220, -2500, -1729, -994, -370, 107, 204, 2518, 193
    };

    // idle and stall odds per phase, in percent
    localparam int SEND_IDLE  [4] = '{0, 75, 0, 25};
    localparam int RECV_STALL [4] = '{0, 0, 75, 25};

    // ------------------------------------------------------------------
    // expected-output tracker: mirrors the delay lines and the enable bit,
    // computes the filtered or echoed pair for every accepted input word
    // ------------------------------------------------------------------
    class highpass_scoreboard;
        bit                         enable;
        logic signed [SAMPLE_W-1:0] left_line  [NTAPS];
        logic signed [SAMPLE_W-1:0] right_line [NTAPS];
        int unsigned                head;
        logic [31:0]                expected_pairs [$];
        int                         errors;

        function new();
            enable = 1'b0;
            head   = 0;
            errors = 0;
            foreach (left_line[i])
            begin
                left_line[i]  = '0;
                right_line[i] = '0;
            end
        endfunction

        // drop 15 fraction bits toward zero, then clamp to int16
        function logic signed [SAMPLE_W-1:0] scale_clamp(longint acc);
            longint q;
            q = acc / 32768;
            if (q > 32767)
            begin
                q = 32767;
            end
            else if (q < -32768)
            begin
                q = -32768;
            end
            return q[SAMPLE_W-1:0];
        endfunction

        // accepted input word: right sample in the upper half, left in the lower
        function void predict_pair(logic [31:0] word);
            longint      acc_l;
            longint      acc_r;
            int unsigned idx;
            if (!enable)
            begin
                // bypass echoes the word, delay lines stay as they are
                expected_pairs.push_back(word);
                return;
            end
            left_line[head]  = word[15:0];
            right_line[head] = word[31:16];
            acc_l = 0;
            acc_r = 0;
            for (int k = 0; k < NTAPS; k++)
            begin
                idx   = (head + NTAPS - k) % NTAPS;
                acc_l += longint'(TAP_COEF[k]) * longint'(left_line[idx]);
                acc_r += longint'(TAP_COEF[k]) * longint'(right_line[idx]);
            end
            head = (head + 1) % NTAPS;
            expected_pairs.push_back({scale_clamp(acc_r), scale_clamp(acc_l)});
        endfunction

        // output word against the oldest pending expectation, channel by channel
        function void compare_pair(logic [31:0] word);
            logic [31:0] want;
            string       chan_name [2];
            chan_name = '{"left_out", "right_out"};
            if (expected_pairs.size() == 0)
            begin
                errors++;
                $display("%0t: output word %h arrived with nothing pending", $time, word);
                return;
            end
            want = expected_pairs.pop_front();
            for (int ch = 0; ch < 2; ch++)
            begin
                if (word[16*ch +: 16] !== want[16*ch +: 16])
                begin
                    errors++;
                    $display("%0t: %s mismatch, expected %0d, got %0d", $time, chan_name[ch],
                             $signed(want[16*ch +: 16]), $signed(word[16*ch +: 16]));
                end
            end
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset and block hookup
    // ------------------------------------------------------------------
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [15:0] left_sample, [31:16] right_sample
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [15:0] left_out, [31:16] right_out
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic        cfg_data      = 1'b0; // [0] filter_enable

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    highpass_scoreboard sb = new();

    always #5 clk = ~clk;

    stereo_fir_highpass #(
        .TAPS (NTAPS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // mostly full-range noise, some corners and some near-zero values
    function automatic logic [15:0] rand_sample();
        logic [15:0] corners [4];
        int          pick;
        corners = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
        pick    = $urandom_range(9);
        if (pick < 2)
        begin
            return corners[$urandom_range(3)];
        end
        if (pick < 4)
        begin
            return 16'($urandom_range(64)) - 16'd32;
        end
        return 16'($urandom_range(65535));
    endfunction

    // offer one word, optionally after random idle cycles; valid stays high
    // on return so back-to-back words need no drop in between
    task automatic send_pair(logic [15:0] left, logic [15:0] right);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {right, left};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.predict_pair({right, left});
    endtask

    // stop offering and wait until every pending output word has arrived
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // enable bit is only changed with the filter idle
    task automatic write_enable(bit value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.enable = value;
    endtask

    // ------------------------------------------------------------------
    // output side: check every accepted word, then pick next stall
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                sb.compare_pair(m_axis_tdata);
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int burst_pos;
        bit burst_flip;
        int mag;
        int v;
        int w;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bypass right after reset: extremes and alternating bit patterns
        send_pair(16'h0000, 16'h0000);
        send_pair(16'h7FFF, 16'h8000);
        send_pair(16'h8000, 16'h7FFF);
        send_pair(16'hFFFF, 16'h0001);
        send_pair(16'h5555, 16'hAAAA);

        // impulse response: opposite-signed extremes walk through the taps
        write_enable(1'b1);
        send_pair(16'h7FFF, 16'h8000);
        for (int i = 0; i < 12; i++)
        begin
            send_pair(16'h0000, 16'h0000);
        end
        send_pair(16'h8000, 16'h7FFF);

        // a bypass word in between must leave the delay lines alone
        write_enable(1'b0);
        send_pair(16'h1234, 16'hFEDC);
        write_enable(1'b1);
        send_pair(16'h0000, 16'h0000);
        send_pair(16'hFFFF, 16'h0001);

        // random phases, each split into two enable settings
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = SEND_IDLE[p];
            recv_stall_pct = RECV_STALL[p];
            for (int half = 0; half < 2; half++)
            begin
                write_enable((half == 0) ^ (p % 2 == 1));
                burst_pos = NTAPS;
                for (int i = 0; i < HALF_ITEMS; i++)
                begin
                    // bursts follow the tap signs so a full one drives the sum
                    // into saturation; some are cut short on purpose
                    if (burst_pos >= NTAPS && $urandom_range(99) < 30)
                    begin
                        burst_pos  = 0;
                        burst_flip = 1'($urandom_range(1));
                    end
                    if (burst_pos < NTAPS)
                    begin
                        mag = $urandom_range(32767, 16384);
                        v   = (TAP_COEF[burst_pos] < 0) ? -mag : mag;
                        if (burst_flip)
                        begin
                            v = -v;
                        end
                        w = -v;
                        send_pair(v[15:0], w[15:0]);
                        burst_pos = ($urandom_range(99) < 4) ? NTAPS : burst_pos + 1;
                    end
                    else
                    begin
                        send_pair(rand_sample(), rand_sample());
                    end
                end
            end
        end

        // let any stray output word show up before the verdict
        drain();
        repeat (LATENCY) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
